@@ hdl/min_lane_change_trellis_macros.svh @@
// Assertion macros for the minimum lane-change trellis.
// Used by the top level; they expand to nothing when SYNTHESIS is defined.
`ifndef MIN_LANE_CHANGE_TRELLIS_MACROS_SVH
`define MIN_LANE_CHANGE_TRELLIS_MACROS_SVH

`ifndef SYNTHESIS

`define MLCT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min_lane_change_trellis: same-cycle check failed");

`define MLCT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min_lane_change_trellis: next-cycle check failed");

`else

`define MLCT_ASSERT_IMP(label, ante, cons)

`define MLCT_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ hdl/mlct_pkg.sv @@
// Shared types and constants for the minimum lane-change trellis.
// No dependencies; every module of the block imports this package.
package mlct_pkg;

    // The lane mask is eight bits wide, so no lane at index 8 or above exists.
    localparam int MASK_W = 8;
    localparam int OUT_W  = 16;

    // Queue between the front and the back; the depth must be a power of two.
    localparam int Q_DEPTH = 4;
    localparam int PTR_W   = $clog2(Q_DEPTH);

    // One classified segment word as it travels from the front to the back.
    typedef struct packed {
        logic [MASK_W-1:0] present;
        logic              last;
    } seg_t;

    // Status of the back, seen by the queue and the top level.
    typedef struct packed {
        logic pop;
        logic snap_valid;
    } back_st_t;

endpackage

@@ hdl/min_lane_change_trellis.sv @@
// Minimum lane-change trellis. Each accepted word is one road segment: a lane-presence
// mask and a flag that marks the last segment of the road. The block keeps, for every
// lane, the least number of lane changes that reaches it, and on the last segment
// returns one word with the least reachable cost (saturating) and a reachable flag,
// then starts over for the next road. Segments stream at one word per clock unless the
// full queue raises seg_stall; the per-lane update is a step of eight small min-plus
// cells. After its last segment is taken, a result passes the input register, the
// queue, the lane update with snapshot, then the registered minimum tree. A four-word
// queue between the input side and the lane update absorbs result-side stalls.
`include "min_lane_change_trellis_macros.svh"

module min_lane_change_trellis #(
    parameter int LANES     = 8,
    parameter int COST_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        seg_valid,
    output logic                        seg_stall,
    input  logic [mlct_pkg::MASK_W-1:0] lane_mask,
    input  logic                        is_last,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [mlct_pkg::OUT_W-1:0]  min_changes,
    output logic                        reachable
);
    import mlct_pkg::*;

    seg_t     f_word;
    seg_t     q_head;
    logic     f_push;
    logic     q_full;
    logic     q_valid;
    back_st_t b_st;

    mlct_front #(
        .LANES(LANES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .lane_mask (lane_mask),
        .is_last   (is_last),
        .q_full    (q_full),
        .push      (f_push),
        .word      (f_word)
    );

    mlct_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (f_word),
        .full  (q_full),
        .pop   (b_st.pop),
        .rdata (q_head),
        .valid (q_valid)
    );

    mlct_back #(
        .LANES     (LANES),
        .COST_BITS (COST_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .head_valid  (q_valid),
        .st          (b_st),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .min_changes (min_changes),
        .reachable   (reachable)
    );

    // A word that ends a road always lands in the snapshot stage.
    `MLCT_ASSERT_NXT(a_last_to_snap, b_st.pop && q_head.last, b_st.snap_valid)
    // A fresh result goes back to a road end popped into the snapshot stage.
    `MLCT_ASSERT_IMP(a_res_origin, $rose(res_valid), $past(b_st.pop && q_head.last, 2))
    // An unreachable answer carries a zero count.
    `MLCT_ASSERT_IMP(a_unreach_zero, res_valid && !reachable, min_changes == '0)

endmodule

@@ hdl/mlct_front.sv @@
// Front of the trellis: input register that accepts segment words and classifies lanes.
// Depends on mlct_pkg; feeds mlct_queue.
module mlct_front #(
    parameter int LANES = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       seg_valid,
    output logic                       seg_stall,
    input  logic [mlct_pkg::MASK_W-1:0] lane_mask,
    input  logic                       is_last,
    input  logic                       q_full,
    output logic                       push,
    output mlct_pkg::seg_t             word
);
    import mlct_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    seg_t  word_reg;
    seg_t  word_next;
    logic  accept;

    assign seg_stall = valid_reg && q_full;
    assign push      = valid_reg && !q_full;
    assign accept    = seg_valid && !seg_stall;
    assign word      = word_reg;

    // Lanes beyond the configured lane count never exist.
    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            word_next.present[i] = lane_mask[i] && (i < LANES);
        end
        word_next.last = is_last;
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

endmodule

@@ hdl/mlct_queue.sv @@
// Short FIFO of classified segment words between the front and the back.
// Depends on mlct_pkg for the word type and the depth.
module mlct_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mlct_pkg::seg_t wdata,
    output logic           full,
    input  logic           pop,
    output mlct_pkg::seg_t rdata,
    output logic           valid
);
    import mlct_pkg::*;

    seg_t             entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full  = (count_reg == (PTR_W + 1)'(Q_DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hdl/mlct_back.sv @@
// Back of the trellis: per-lane min-plus update, end-of-road snapshot and minimum tree.
// Depends on mlct_pkg; takes words from mlct_queue and drives the result channel.
module mlct_back #(
    parameter int LANES     = 8,
    parameter int COST_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mlct_pkg::seg_t             head,
    input  logic                       head_valid,
    output mlct_pkg::back_st_t         st,
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic [mlct_pkg::OUT_W-1:0] min_changes,
    output logic                       reachable
);
    import mlct_pkg::*;

    localparam int LVL    = $clog2(LANES);
    localparam int LEAVES = 1 << LVL;
    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    logic [COST_BITS-1:0] cost_reg [LANES];
    logic [LANES-1:0]     live_reg;
    logic                 first_reg;
    logic [LANES-1:0]     pres;
    logic [COST_BITS-1:0] cost_next [LEAVES];
    logic [LEAVES-1:0]    live_next;

    logic                 snap_valid_reg;
    logic                 snap_valid_next;
    logic [COST_BITS-1:0] snap_cost_reg [LEAVES];
    logic [LEAVES-1:0]    snap_live_reg;

    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic [OUT_W-1:0]     min_changes_reg;
    logic                 reachable_reg;

    logic                 snap_go;
    logic                 snap_free;
    logic                 pop;
    logic                 pop_last;

    logic [COST_BITS-1:0] t_cost [LVL+1][LEAVES];
    logic                 t_live [LVL+1][LEAVES];
    logic [COST_BITS-1:0] root_cost;
    logic [OUT_W-1:0]     root_out;

    function automatic logic [COST_BITS-1:0] sat_inc(input logic [COST_BITS-1:0] v);
        return (v == COST_MAX) ? v : v + 1'b1;
    endfunction

    // A word that ends a road may only leave the queue when the snapshot stage is free.
    assign snap_go   = snap_valid_reg && (!res_valid_reg || !res_stall);
    assign snap_free = !snap_valid_reg || snap_go;
    assign pop       = head_valid && (!head.last || snap_free);
    assign pop_last  = pop && head.last;

    assign st.pop        = pop;
    assign st.snap_valid = snap_valid_reg;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic [COST_BITS-1:0] l_cost;
        logic [COST_BITS-1:0] r_cost;
        logic                 l_live;
        logic                 r_live;
        logic [COST_BITS-1:0] best;
        logic                 have;

        if (i < MASK_W)
        begin : g_pres
            assign pres[i] = head.present[i];
        end
        else
        begin : g_abs
            assign pres[i] = 1'b0;
        end

        if (i > 0)
        begin : g_left
            assign l_live = live_reg[i-1];
            assign l_cost = sat_inc(cost_reg[i-1]);
        end
        else
        begin : g_no_left
            assign l_live = 1'b0;
            assign l_cost = '0;
        end

        if (i + 1 < LANES)
        begin : g_right
            assign r_live = live_reg[i+1];
            assign r_cost = sat_inc(cost_reg[i+1]);
        end
        else
        begin : g_no_right
            assign r_live = 1'b0;
            assign r_cost = '0;
        end

        always_comb
        begin
            best = cost_reg[i];
            have = live_reg[i];
            if (l_live && (!have || l_cost < best))
            begin
                best = l_cost;
                have = 1'b1;
            end
            if (r_live && (!have || r_cost < best))
            begin
                best = r_cost;
                have = 1'b1;
            end
            if (!pres[i])
            begin
                live_next[i] = 1'b0;
                cost_next[i] = '0;
            end
            else if (first_reg)
            begin
                live_next[i] = 1'b1;
                cost_next[i] = '0;
            end
            else
            begin
                live_next[i] = have;
                cost_next[i] = have ? best : '0;
            end
        end
    end

    // Padding leaves of the minimum tree never hold a reachable lane.
    for (genvar i = LANES; i < LEAVES; i++)
    begin : g_pad
        assign live_next[i] = 1'b0;
        assign cost_next[i] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                cost_reg[i] <= '0;
            end
            live_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (pop)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                cost_reg[i] <= head.last ? '0 : cost_next[i];
            end
            live_reg  <= head.last ? '0 : live_next[LANES-1:0];
            first_reg <= head.last;
        end
    end

    always_comb
    begin
        if (pop_last)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_go)
        begin
            snap_valid_next = 1'b0;
        end
        else
        begin
            snap_valid_next = snap_valid_reg;
        end

        if (snap_go)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_last)
        begin
            for (int k = 0; k < LEAVES; k++)
            begin
                snap_cost_reg[k] <= cost_next[k];
            end
            snap_live_reg <= live_next;
        end
    end

    // Pairwise minimum over the snapshot, one tree level per outer iteration.
    always_comb
    begin
        for (int l = 0; l <= LVL; l++)
        begin
            for (int k = 0; k < LEAVES; k++)
            begin
                t_cost[l][k] = '0;
                t_live[l][k] = 1'b0;
            end
        end
        for (int k = 0; k < LEAVES; k++)
        begin
            t_cost[0][k] = snap_cost_reg[k];
            t_live[0][k] = snap_live_reg[k];
        end
        for (int l = 0; l < LVL; l++)
        begin
            for (int k = 0; k < (LEAVES >> (l + 1)); k++)
            begin
                if (t_live[l][2*k] &&
                    (!t_live[l][2*k+1] || t_cost[l][2*k] <= t_cost[l][2*k+1]))
                begin
                    t_cost[l+1][k] = t_cost[l][2*k];
                end
                else
                begin
                    t_cost[l+1][k] = t_cost[l][2*k+1];
                end
                t_live[l+1][k] = t_live[l][2*k] || t_live[l][2*k+1];
            end
        end
    end

    assign root_cost = t_cost[LVL][0];

    if (COST_BITS > OUT_W)
    begin : g_sat_out
        assign root_out = (|root_cost[COST_BITS-1:OUT_W]) ? '1 : root_cost[OUT_W-1:0];
    end
    else
    begin : g_ext_out
        assign root_out = OUT_W'(root_cost);
    end

    always_ff @(posedge clk)
    begin
        if (snap_go)
        begin
            reachable_reg   <= t_live[LVL][0];
            min_changes_reg <= t_live[LVL][0] ? root_out : '0;
        end
    end

    assign res_valid   = res_valid_reg;
    assign min_changes = min_changes_reg;
    assign reachable   = reachable_reg;

endmodule

@@ tb/min_lane_change_trellis_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for min_lane_change_trellis: a directed table, random roads,
// a back-pressure burst and one long zigzag road whose cost climbs every segment.
// Depends on mlct_pkg and the RTL of the block only.

module min_lane_change_trellis_tb;
    import mlct_pkg::*;

    localparam int          NUM_LANES       = 8;
    localparam logic [15:0] COST_TOP        = 16'hFFFF;
    localparam int          IDLE_LIMIT      = 2000;
    localparam int          DRAIN_CYCLES    = 10;
    localparam int          LONG_HOLD       = 150;
    localparam int          RANDOM_SEGMENTS = 1020;
    localparam int          ZIGZAG_SEGMENTS = 64;
    localparam int          REPORT_MAX      = 10;

    typedef struct packed {
        logic [OUT_W-1:0] min_changes;
        logic             reachable;
    } answer_t;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              last;
        logic              typed;
        logic [OUT_W-1:0]  exp_min;
        logic              exp_reach;
    } seg_row_t;

    logic              clk;
    logic              rst_n;
    logic              seg_valid;
    logic              seg_stall;
    logic [MASK_W-1:0] lane_mask;
    logic              is_last;
    logic              res_valid;
    logic              res_stall;
    logic [OUT_W-1:0]  min_changes;
    logic              reachable;

    // Lane state of the road in progress, as the block should hold it.
    logic [15:0] lane_cost [NUM_LANES];
    logic        lane_live [NUM_LANES];
    logic        road_start;

    answer_t answers_due [$];
    answer_t want_word;
    answer_t got_word;

    int mismatches       = 0;
    int roads_done       = 0;
    int segs_sent        = 0;
    int unreachable_seen = 0;
    int saturated_seen   = 0;
    int stall_cycles     = 0;
    int idle_cycles      = 0;
    bit long_hold_req    = 1'b0;
    bit res_taken        = 1'b0;

    // Rows with typed answers are single-segment roads and roads that plainly break.
    seg_row_t directed_rows [23] = '{
        '{8'hFF, 1'b1, 1'b1, 16'd0, 1'b1},
        '{8'h00, 1'b1, 1'b1, 16'd0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 16'd0, 1'b1},
        '{8'h01, 1'b1, 1'b1, 16'd0, 1'b1},
        '{8'h01, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h02, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h04, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h08, 1'b1, 1'b0, 16'd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h40, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h20, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h10, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h08, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h04, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h02, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h01, 1'b1, 1'b0, 16'd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 16'd0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h80, 1'b1, 1'b1, 16'd0, 1'b0},
        '{8'h55, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hAA, 1'b1, 1'b0, 16'd0, 1'b0}
    };

    min_lane_change_trellis dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .seg_valid   (seg_valid),
        .seg_stall   (seg_stall),
        .lane_mask   (lane_mask),
        .is_last     (is_last),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .min_changes (min_changes),
        .reachable   (reachable)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_road();
        for (int i = 0; i < NUM_LANES; i++)
        begin
            lane_cost[i] = '0;
            lane_live[i] = 1'b0;
        end
        road_start = 1'b1;
    endfunction

    // One min-plus step over the lanes; returns 1 when the segment closes a road.
    function automatic bit advance_lanes(input logic [MASK_W-1:0] mask, input logic last,
                                         output answer_t ans);
        logic [15:0] next_cost [NUM_LANES];
        logic        next_live [NUM_LANES];
        logic [15:0] best;
        logic [15:0] step;
        logic        have;

        ans = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            next_cost[i] = '0;
            next_live[i] = 1'b0;
            if (!mask[i])
                continue;
            if (road_start)
            begin
                next_live[i] = 1'b1;
                continue;
            end
            have = 1'b0;
            best = '0;
            if (lane_live[i])
            begin
                best = lane_cost[i];
                have = 1'b1;
            end
            if (i > 0 && lane_live[i-1])
            begin
                step = (lane_cost[i-1] == COST_TOP) ? COST_TOP : lane_cost[i-1] + 16'd1;
                if (!have || step < best)
                    best = step;
                have = 1'b1;
            end
            if (i + 1 < NUM_LANES && lane_live[i+1])
            begin
                step = (lane_cost[i+1] == COST_TOP) ? COST_TOP : lane_cost[i+1] + 16'd1;
                if (!have || step < best)
                    best = step;
                have = 1'b1;
            end
            next_live[i] = have;
            next_cost[i] = have ? best : 16'd0;
        end
        for (int i = 0; i < NUM_LANES; i++)
        begin
            lane_cost[i] = next_cost[i];
            lane_live[i] = next_live[i];
        end
        road_start = 1'b0;
        if (!last)
            return 1'b0;

        have = 1'b0;
        best = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (lane_live[i] && (!have || lane_cost[i] < best))
            begin
                best = lane_cost[i];
                have = 1'b1;
            end
        end
        ans.min_changes = have ? best : 16'd0;
        ans.reachable   = have;
        clear_road();
        return 1'b1;
    endfunction

    function automatic int sender_gap();
        return ((segs_sent / 48) % 5 == 2) ? 0 : $urandom_range(0, 7);
    endfunction

    // Mostly dense or banded masks so that roads stay reachable; a fifth is pure noise.
    function automatic logic [MASK_W-1:0] pick_mask();
        int                kind;
        int                lo;
        int                hi;
        logic [MASK_W-1:0] m;

        kind = $urandom_range(0, 9);
        if (kind < 2)
            return MASK_W'($urandom_range(0, 255));
        m = '1;
        if (kind < 6)
        begin
            m[$urandom_range(0, 7)] = 1'b0;
            if ($urandom_range(0, 1) == 1)
                m[$urandom_range(0, 7)] = 1'b0;
            return m;
        end
        lo = $urandom_range(0, 7);
        hi = $urandom_range(lo, 7);
        m  = '0;
        for (int i = lo; i <= hi; i++)
            m[i] = 1'b1;
        return m;
    endfunction

    task automatic report_mismatch(input string what, input answer_t want, input answer_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch (%s): expected min=%0d reach=%0b, got min=%0d reach=%0b",
                     what, want.min_changes, want.reachable, got.min_changes, got.reachable);
    endtask

    // Called just after a falling edge; returns just after the falling edge that follows
    // acceptance, which is where the answer for a closed road is queued.
    task automatic send_word(input logic [MASK_W-1:0] mask, input logic last, input int gap,
                             input logic typed = 1'b0, input answer_t typed_ans = '0);
        answer_t ans;

        if (gap > 0)
        begin
            seg_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        seg_valid <= 1'b1;
        lane_mask <= mask;
        is_last   <= last;
        do
            @(posedge clk);
        while (seg_stall);
        @(negedge clk);
        segs_sent++;
        if (advance_lanes(mask, last, ans))
            answers_due.insert(answers_due.size(), typed ? typed_ans : ans);
    endtask

    task automatic drain();
        seg_valid <= 1'b0;
        do
            @(negedge clk);
        while (answers_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int      len;
        int      random_sent;
        answer_t row_ans;

        seg_valid   = 1'b0;
        lane_mask   = '0;
        is_last     = 1'b0;
        rst_n       = 1'b0;
        random_sent = 0;
        clear_road();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            row_ans.min_changes = directed_rows[r].exp_min;
            row_ans.reachable   = directed_rows[r].exp_reach;
            send_word(directed_rows[r].mask, directed_rows[r].last, sender_gap(),
                      directed_rows[r].typed, row_ans);
        end
        drain();

        // The result side holds off while single-segment roads pour in back to back,
        // so the queue fills and the input must stall.
        @(posedge clk);
        long_hold_req = 1'b1;
        @(negedge clk);
        repeat (40) send_word(pick_mask(), 1'b1, 0);
        drain();

        while (random_sent < RANDOM_SEGMENTS)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
                send_word(pick_mask(), k == len - 1, sender_gap());
            random_sent += len;
            if ($urandom_range(0, 29) == 0)
                drain();
        end
        drain();

        // Zigzag between lanes 0 and 1 costs one change per segment, so the answer
        // grows with the length of the road.
        for (int k = 0; k < ZIGZAG_SEGMENTS; k++)
            send_word(k[0] ? 8'h02 : 8'h01, k == ZIGZAG_SEGMENTS - 1, 0);
        drain();

        $display("Sent %0d segments over %0d roads; %0d unreachable, %0d saturated.",
                 segs_sent, roads_done, unreachable_seen, saturated_seen);
        $display("Input held by back-pressure for %0d cycles; %0d mismatching words.",
                 stall_cycles, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side: a random hold-off before each word, with one long hold on request.
    initial
    begin
        int stall_left;

        res_stall  = 1'b0;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                res_taken     = 1'b0;
                stall_left    = LONG_HOLD;
            end
            else if (res_taken)
            begin
                res_taken  = 1'b0;
                stall_left = ((roads_done / 12) % 5 == 3) ? 0 : $urandom_range(0, 7);
            end
            if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (seg_valid && seg_stall)
                stall_cycles++;
            if (res_valid && !res_stall)
            begin
                res_taken = 1'b1;
                roads_done++;
                got_word.min_changes = min_changes;
                got_word.reachable   = reachable;
                if (!reachable)
                    unreachable_seen++;
                if (min_changes == COST_TOP)
                    saturated_seen++;
                if (answers_due.size() == 0)
                    report_mismatch("no answer pending", '0, got_word);
                else
                begin
                    want_word = answers_due.pop_front();
                    if (want_word.min_changes !== got_word.min_changes
                        || want_word.reachable !== got_word.reachable)
                        report_mismatch("wrong answer", want_word, got_word);
                end
            end
            if ((seg_valid && !seg_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles, %0d answers outstanding.",
                         IDLE_LIMIT, answers_due.size());
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mlct_pkg.sv
hdl/mlct_front.sv
hdl/mlct_queue.sv
hdl/mlct_back.sv
hdl/min_lane_change_trellis.sv
tb/min_lane_change_trellis_tb.sv
